// File: hdl/aesfrk_pkg.sv
// Shared types, constants and the byte substitution table for the
// AES-128 final round key pipeline. No dependencies.
package aesfrk_pkg;

  localparam int KEY_WORDS      = 4;
  localparam int WORD_BITS      = 32;
  localparam int RCON_LEN       = 10;
  localparam int ROUND_COUNT_DF = 10;

  typedef logic [WORD_BITS-1:0] word_t;

  // One beat as it moves down the pipeline: the valid bit travels with the key.
  typedef struct packed {
    logic                       valid;
    logic [KEY_WORDS-1:0][WORD_BITS-1:0] key;
  } stage_t;

  localparam logic [7:0] RCON [RCON_LEN] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // RotWord followed by SubWord.
  function automatic word_t rot_sub(input word_t w);
    rot_sub = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

endpackage

// File: hdl/aesfrk_combine.sv
// Entry stage: combines seed and random key into the cipher key and registers it.
// Depends on aesfrk_pkg.
module aesfrk_combine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [63:0]          seed_high,
  input  logic [63:0]          seed_low,
  input  logic [63:0]          random_high,
  input  logic [63:0]          random_low,
  output aesfrk_pkg::stage_t   stage_out
);
  import aesfrk_pkg::*;

  logic                                valid_r;
  logic [KEY_WORDS-1:0][WORD_BITS-1:0] key_r;
  logic [KEY_WORDS-1:0][WORD_BITS-1:0] key_nxt;

  assign key_nxt = {seed_high ^ random_high, seed_low ^ random_low};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key_nxt;
    end
  end

  assign stage_out = '{valid: valid_r, key: key_r};

endmodule

// File: hdl/aesfrk_round.sv
// One key schedule round as a register stage.
// Depends on aesfrk_pkg for the S-box, round constants and the stage type.
module aesfrk_round #(
  parameter int ROUND_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aesfrk_pkg::stage_t stage_in,
  output aesfrk_pkg::stage_t stage_out
);
  import aesfrk_pkg::*;

  logic                                valid_r;
  logic [KEY_WORDS-1:0][WORD_BITS-1:0] key_r;
  logic [KEY_WORDS-1:0][WORD_BITS-1:0] key_nxt;
  word_t w0, w1, w2, w3;

  // Word 0 sits in the top 32 bits of the packed key.
  always_comb begin
    w0 = stage_in.key[3] ^ rot_sub(stage_in.key[0]) ^ {RCON[ROUND_IDX], 24'h000000};
    w1 = stage_in.key[2] ^ w0;
    w2 = stage_in.key[1] ^ w1;
    w3 = stage_in.key[0] ^ w2;
    key_nxt = {w0, w1, w2, w3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_in.valid) begin
      key_r <= key_nxt;
    end
  end

  assign stage_out = '{valid: valid_r, key: key_r};

endmodule

// File: hdl/aes128_final_round_key.sv
// Top level of the AES-128 final round key pipeline.
// Depends on aesfrk_pkg, aesfrk_combine and aesfrk_round.
//
// Usage: drive the seed and random key halves on the in_ ports and raise
// start. A beat is taken at every rising edge where start is high and busy
// is low. The two keys are XORed into an AES-128 cipher key, the standard
// key schedule runs one round per register stage, and only the last round
// key comes out on out_key_word0..3 with out_valid high for one cycle.
// The key passes through one entry stage and then one register stage per
// round. Every stage can take a fresh beat each cycle, so one key can be
// taken per cycle whenever busy is low and start is high.
// busy is high only during reset and in the first cycle after it; the
// pipeline then never stalls. The receiver cannot hold results off and
// must take each one in the cycle it is shown. Reset clears all valid
// bits, so beats in flight at reset are dropped.
module aes128_final_round_key #(
  parameter int ROUND_COUNT = aesfrk_pkg::ROUND_COUNT_DF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_seed_high,
  input  logic [63:0] in_seed_low,
  input  logic [63:0] in_random_high,
  input  logic [63:0] in_random_low,
  output logic        out_valid,
  output logic [31:0] out_key_word0,
  output logic [31:0] out_key_word1,
  output logic [31:0] out_key_word2,
  output logic [31:0] out_key_word3
);
  import aesfrk_pkg::*;

  localparam int LATENCY = ROUND_COUNT + 1;

  stage_t stages [ROUND_COUNT+1];
  logic   busy_r;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r | !rst_n;
  assign accept = start & !busy;

  aesfrk_combine u_combine (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .seed_high   (in_seed_high),
    .seed_low    (in_seed_low),
    .random_high (in_random_high),
    .random_low  (in_random_low),
    .stage_out   (stages[0])
  );

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    aesfrk_round #(
      .ROUND_IDX (r)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (stages[r]),
      .stage_out (stages[r+1])
    );
  end

  assign out_valid     = stages[ROUND_COUNT].valid;
  assign out_key_word0 = stages[ROUND_COUNT].key[3];
  assign out_key_word1 = stages[ROUND_COUNT].key[2];
  assign out_key_word2 = stages[ROUND_COUNT].key[1];
  assign out_key_word3 = stages[ROUND_COUNT].key[0];

  // Every result must trace back to an accepted beat that passed through every stage.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching accepted beat");

  // Every accepted beat must come out, none lost in the pipeline.
  a_beat_comes_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, LATENCY) && $past(rst_n, LATENCY - 1) |-> out_valid)
    else $error("accepted beat did not produce a result");

  // Reset empties the pipeline and blocks input in the cycle after.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("pipeline not cleared by reset");

endmodule

// File: test/testbench.sv
// Self-checking testbench for aes128_final_round_key: random and directed key pairs,
// with its own key-schedule predictor and an in-order check of every result beat.
// Depends on aesfrk_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aesfrk_pkg::word_t;

  localparam int ROUNDS       = 10;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_TAIL    = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 3 * (ROUNDS + 1);

  typedef struct {
    logic [63:0] seed_high;
    logic [63:0] seed_low;
    logic [63:0] random_high;
    logic [63:0] random_low;
  } key_pair_t;

  typedef struct {
    word_t word [4];
  } round_key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_seed_high = '0;
  logic [63:0] in_seed_low = '0;
  logic [63:0] in_random_high = '0;
  logic [63:0] in_random_low = '0;
  logic        out_valid;
  word_t       out_key_word0, out_key_word1, out_key_word2, out_key_word3;

  key_pair_t   key_pairs_pending [$];
  round_key_t  round_keys_expected [$];
  logic [7:0]  sub_byte_tbl [256];
  int          error_count = 0;
  int          total_items = 0;
  int          beats_taken = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;

  aes128_final_round_key #(.ROUND_COUNT(ROUNDS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_seed_high   (in_seed_high),
    .in_seed_low    (in_seed_low),
    .in_random_high (in_random_high),
    .in_random_low  (in_random_low),
    .out_valid      (out_valid),
    .out_key_word0  (out_key_word0),
    .out_key_word1  (out_key_word1),
    .out_key_word2  (out_key_word2),
    .out_key_word3  (out_key_word3)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = xtime(x);
    end
    return acc;
  endfunction

  // The substitution table is derived from the field inverse and the affine map,
  // so it does not share a typo with any hand-written table.
  task automatic build_sub_bytes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_byte_tbl[x] = s;
    end
  endtask

  function automatic round_key_t last_round_key(input logic [63:0] hi, input logic [63:0] lo);
    round_key_t k;
    word_t      t;
    logic [7:0] rc;
    k.word[0] = hi[63:32];
    k.word[1] = hi[31:0];
    k.word[2] = lo[63:32];
    k.word[3] = lo[31:0];
    rc = 8'h01;
    for (int r = 0; r < ROUNDS && r < 10; r++) begin
      t = {sub_byte_tbl[k.word[3][23:16]], sub_byte_tbl[k.word[3][15:8]],
           sub_byte_tbl[k.word[3][7:0]], sub_byte_tbl[k.word[3][31:24]]};
      k.word[0] ^= t ^ {rc, 24'h0};
      k.word[1] ^= k.word[0];
      k.word[2] ^= k.word[1];
      k.word[3] ^= k.word[2];
      rc = xtime(rc);
    end
    return k;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_pair(input logic [63:0] sh, input logic [63:0] sl,
                          input logic [63:0] rh, input logic [63:0] rl);
    key_pair_t p;
    p.seed_high = sh;
    p.seed_low = sl;
    p.random_high = rh;
    p.random_low = rl;
    key_pairs_pending.push_back(p);
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: holds a beat until the edge that takes it, and idles in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        round_keys_expected.push_back(last_round_key(in_seed_high ^ in_random_high,
                                                     in_seed_low ^ in_random_low));
        key_pairs_pending.pop_front();
        beats_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beats_taken + CALM_TAIL < total_items && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          start <= 1'b0;
        end else if (key_pairs_pending.size() > 0) begin
          start          <= 1'b1;
          in_seed_high   <= key_pairs_pending[0].seed_high;
          in_seed_low    <= key_pairs_pending[0].seed_low;
          in_random_high <= key_pairs_pending[0].random_high;
          in_random_low  <= key_pairs_pending[0].random_low;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat must match the oldest outstanding expectation.
  always @(posedge clk) begin
    round_key_t got;
    round_key_t want;
    if (rst_n && out_valid) begin
      got.word[0] = out_key_word0;
      got.word[1] = out_key_word1;
      got.word[2] = out_key_word2;
      got.word[3] = out_key_word3;
      if (round_keys_expected.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat %h %h %h %h",
                                got.word[0], got.word[1], got.word[2], got.word[3]));
      end else begin
        want = round_keys_expected.pop_front();
        for (int i = 0; i < 4; i++)
          if (got.word[i] !== want.word[i])
            note_mismatch($sformatf("key_word%0d got %h expected %h",
                                    i, got.word[i], want.word[i]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] sh, sl, rh, rl;
    logic [63:0] flips;
    build_sub_bytes();

    // Directed part: extreme and patterned keys.
    add_pair('0, '0, '0, '0);
    add_pair('1, '1, '0, '0);
    add_pair('0, '0, '1, '1);
    add_pair('1, '1, '1, '1);
    add_pair(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0);
    add_pair('0, '0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    add_pair(64'h5555555555555555, 64'h5555555555555555,
             64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa);
    add_pair(64'h8000000000000000, '0, '0, 64'h0000000000000001);
    add_pair('0, 64'h8000000000000000, 64'h0000000000000001, '0);
    add_pair(64'h0123456789abcdef, 64'hfedcba9876543210,
             64'h0123456789abcdef, 64'hfedcba9876543210);
    add_pair(64'hff00ff00ff00ff00, 64'h00ff00ff00ff00ff, '0, '1);
    add_pair(64'h000102030405060a, 64'h08090a0b0c0d0e0f, '0, '0);
    add_pair(64'h6363636363636363, 64'h6363636363636363, '0, '0);
    add_pair(64'h7fffffffffffffff, 64'hfffffffffffffffe, '1, '0);

    // Random part: dense keys in half the cases, with sparse and near-cancelling pairs mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sh = rand64();
      sl = rand64();
      rh = rand64();
      rl = rand64();
      case ($urandom_range(0, 5))
        1: begin
          flips = 64'h1 << $urandom_range(0, 63);
          rh = sh ^ flips;
          rl = sl ^ (64'h1 << $urandom_range(0, 63));
        end
        2: begin
          if ($urandom_range(0, 1)) begin
            sl = '0;
            rh = '0;
            rl = '0;
          end else begin
            sh = '1;
            rl = '1;
          end
        end
        3: begin
          for (int b = 0; b < 8; b++) begin
            case ($urandom_range(0, 2))
              0: sh[b*8 +: 8] = 8'h00;
              1: sh[b*8 +: 8] = 8'hff;
              default: ;
            endcase
            if ($urandom_range(0, 1)) sl[b*8 +: 8] = rl[b*8 +: 8];
          end
        end
        default: ;
      endcase
      add_pair(sh, sl, rh, rl);
    end
    total_items = key_pairs_pending.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (key_pairs_pending.size() != 0 || start);
    do @(negedge clk); while (round_keys_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (round_keys_expected.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", round_keys_expected.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/aesfrk_pkg.sv
hdl/aesfrk_combine.sv
hdl/aesfrk_round.sv
hdl/aes128_final_round_key.sv
test/testbench.sv
